/* design/c2p_pkg.sv */
// Shared types and constants for the conserved-to-primitive converter.
package c2p_pkg;
  localparam int Dimensions = 3;
  localparam int GammaW = 19;
  localparam logic [GammaW-1:0] GammaReset = 19'd26214;
  localparam int QDepth = 4;
  localparam int QAw = 2;
  localparam int ODepth = 4;
  localparam int OAw = 2;
  localparam int DivSteps = 48;

  typedef struct packed {
    logic [31:0] density;
    logic [31:0] mom_x;
    logic [31:0] mom_y;
    logic [31:0] mom_z;
    logic [31:0] energy;
    logic [31:0] tracer;
    logic        zero;
  } c2p_cell_t;

  typedef struct packed {
    logic [31:0] density_out;
    logic [31:0] velocity_x;
    logic [31:0] velocity_y;
    logic [31:0] velocity_z;
    logic [31:0] pressure;
    logic [31:0] tracer_out;
    logic        zero_density;
    logic        saturated;
  } c2p_res_t;
endpackage

/* design/c2p_front.sv */
// Front end: accept a cell, mask unused components, flag zero density, queue it.
module c2p_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [31:0]        in_density,
  input  logic signed [31:0] in_momentum_x,
  input  logic signed [31:0] in_momentum_y,
  input  logic signed [31:0] in_momentum_z,
  input  logic [31:0]        in_total_energy,
  input  logic [31:0]        in_tracer_in,
  output logic               q_valid,
  input  logic               q_take,
  output c2p_pkg::c2p_cell_t q_cell
);
  import c2p_pkg::*;

  c2p_cell_t        mem_r [QDepth];
  logic [QAw-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAw:0]     cnt_r, cnt_nxt;
  logic             push_ok, take_ok;
  c2p_cell_t        item;

  always_comb begin
    item.density = in_density;
    item.mom_x   = in_momentum_x;
    item.mom_y   = (Dimensions >= 2) ? in_momentum_y : 32'd0;
    item.mom_z   = (Dimensions >= 3) ? in_momentum_z : 32'd0;
    item.energy  = in_total_energy;
    item.tracer  = in_tracer_in;
    item.zero    = (in_density == 32'd0);
  end

  assign in_full = (cnt_r == (QAw+1)'(QDepth));
  assign q_valid = (cnt_r != '0);
  assign q_cell  = mem_r[rp_r];
  assign push_ok = in_push && !in_full;
  assign take_ok = q_take && q_valid;

  always_comb begin
    wp_nxt  = push_ok ? wp_r + 1'b1 : wp_r;
    rp_nxt  = take_ok ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + {{QAw{1'b0}}, push_ok} - {{QAw{1'b0}}, take_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
    if (push_ok) mem_r[wp_r] <= item;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAw+1)'(QDepth)) else $error("queue count overrun");
  a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !take_ok) else $error("take from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push_ok && !take_ok) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("count did not advance");
endmodule

/* design/c2p_back.sv */
// Back end: pipelined divide, square, kinetic and pressure stages with output queue.
module c2p_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [c2p_pkg::GammaW-1:0]   gamma,
  input  logic                         q_valid,
  output logic                         q_take,
  input  c2p_pkg::c2p_cell_t           q_cell,
  output logic                         res_valid,
  input  logic                         res_take,
  output c2p_pkg::c2p_res_t            res
);
  import c2p_pkg::*;

  // divider pipeline: one quotient bit per stage for each of three lanes
  logic             dv_r   [DivSteps+1];
  c2p_cell_t        dc_r   [DivSteps+1];
  logic [47:0]      num_r  [DivSteps+1][3];
  logic [32:0]      rem_r  [DivSteps+1][3];
  logic [47:0]      quo_r  [DivSteps+1][3];
  logic [2:0]       neg_r  [DivSteps+1];

  logic             adv;
  logic             f_v_r;
  logic [OAw:0]     ocnt_r, ocnt_nxt;

  // advance the whole pipe unless the last stage holds a beat with no room for it
  assign adv    = !f_v_r || (ocnt_r != (OAw+1)'(ODepth));
  assign q_take = q_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (adv) dv_r[0] <= q_take;
    if (adv) begin
      dc_r[0] <= q_cell;
      for (int l = 0; l < 3; l++) begin
        logic [31:0] mm;
        logic        ng;
        mm = (l == 0) ? q_cell.mom_x : (l == 1) ? q_cell.mom_y : q_cell.mom_z;
        ng = mm[31];
        neg_r[0][l]   <= ng;
        num_r[0][l]   <= {(ng ? (32'd0 - mm) : mm), 16'd0};
        rem_r[0][l]   <= '0;
        quo_r[0][l]   <= '0;
      end
    end
  end

  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[s+1] <= 1'b0;
      else if (adv) dv_r[s+1] <= dv_r[s];
      if (adv) begin
        dc_r[s+1]  <= dc_r[s];
        neg_r[s+1] <= neg_r[s];
        for (int l = 0; l < 3; l++) begin
          logic [32:0] tr;
          tr = {rem_r[s][l][31:0], num_r[s][l][47]};
          num_r[s+1][l] <= {num_r[s][l][46:0], 1'b0};
          if (tr >= {1'b0, dc_r[s].density}) begin
            rem_r[s+1][l] <= tr - {1'b0, dc_r[s].density};
            quo_r[s+1][l] <= {quo_r[s][l][46:0], 1'b1};
          end else begin
            rem_r[s+1][l] <= tr;
            quo_r[s+1][l] <= {quo_r[s][l][46:0], 1'b0};
          end
        end
      end
    end
  end

  // stage A: clamp velocities
  logic        a_v_r;
  c2p_cell_t   a_c_r;
  logic [31:0] a_vel_r [3];
  logic [31:0] a_mag_r [3];
  logic        a_sat_r;
  always_ff @(posedge clk) begin
    logic s;
    logic [47:0] q;
    logic [31:0] mg;
    s = 1'b0;
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        q = quo_r[DivSteps][l];
        if (neg_r[DivSteps][l]) begin
          if (q > 48'h80000000) begin mg = 32'h80000000; s = 1'b1; end
          else mg = q[31:0];
          a_vel_r[l] <= 32'd0 - mg;
        end else begin
          if (q > 48'h7FFFFFFF) begin mg = 32'h7FFFFFFF; s = 1'b1; end
          else mg = q[31:0];
          a_vel_r[l] <= mg;
        end
        a_mag_r[l] <= mg;
      end
      a_sat_r <= s;
      a_c_r   <= dc_r[DivSteps];
    end
    if (!rst_n) a_v_r <= 1'b0; else if (adv) a_v_r <= dv_r[DivSteps];
  end

  // stage B: squares
  logic        b_v_r;  c2p_cell_t b_c_r;  logic b_sat_r;
  logic [31:0] b_vel_r [3];
  logic [63:0] b_sq_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) b_sq_r[l] <= a_mag_r[l] * a_mag_r[l];
      b_vel_r <= a_vel_r; b_c_r <= a_c_r; b_sat_r <= a_sat_r;
    end
    if (!rst_n) b_v_r <= 1'b0; else if (adv) b_v_r <= a_v_r;
  end

  // stage C: speed squared (Q34.32, 66 bits)
  logic        c_v_r;  c2p_cell_t c_c_r;  logic c_sat_r;
  logic [31:0] c_vel_r [3];
  logic [65:0] c_vsq_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      c_vsq_r <= {2'b0, b_sq_r[0]} + {2'b0, b_sq_r[1]} + {2'b0, b_sq_r[2]};
      c_vel_r <= b_vel_r; c_c_r <= b_c_r; c_sat_r <= b_sat_r;
    end
    if (!rst_n) c_v_r <= 1'b0; else if (adv) c_v_r <= b_v_r;
  end

  // stage D: rho * vsq split into partial products
  logic        d_v_r;  c2p_cell_t d_c_r;  logic d_sat_r;
  logic [31:0] d_vel_r [3];
  logic [63:0] d_lo_r;
  logic [65:0] d_hi_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      d_lo_r <= c_c_r.density * c_vsq_r[31:0];
      d_hi_r <= c_c_r.density * {32'd0, c_vsq_r[65:32]};
      d_vel_r <= c_vel_r; d_c_r <= c_c_r; d_sat_r <= c_sat_r;
    end
    if (!rst_n) d_v_r <= 1'b0; else if (adv) d_v_r <= c_v_r;
  end

  // stage E: kinetic term and energy difference
  logic        e_v_r;  c2p_cell_t e_c_r;  logic e_sat_r;
  logic [31:0] e_vel_r [3];
  logic        e_neg_r;
  logic [66:0] e_mag_r;
  always_ff @(posedge clk) begin
    logic [66:0] sm, kin, en;
    sm  = {1'b0, d_hi_r} + {35'd0, d_lo_r[63:32]};
    kin = sm >> 1;
    en  = {35'd0, d_c_r.energy};
    if (adv) begin
      if (kin > en) begin e_neg_r <= 1'b1; e_mag_r <= kin - en; end
      else begin e_neg_r <= 1'b0; e_mag_r <= en - kin; end
      e_vel_r <= d_vel_r; e_c_r <= d_c_r; e_sat_r <= d_sat_r;
    end
    if (!rst_n) e_v_r <= 1'b0; else if (adv) e_v_r <= d_v_r;
  end

  // stage F: scale by gamma, floor and clamp; a magnitude of 2^48 or more
  // clamps outright since any non-zero gamma lifts it past the range
  c2p_res_t    f_res_r;
  always_ff @(posedge clk) begin
    logic [66:0] p;
    logic [50:0] q;
    logic        big, s;
    logic [31:0] pr;
    big = (e_mag_r[66:48] != '0);
    p   = e_mag_r[47:0] * gamma;
    q   = p[66:16] + {50'd0, e_neg_r && (p[15:0] != 16'd0)};
    s   = 1'b0;
    if (gamma == '0 || e_mag_r == '0) pr = 32'd0;
    else if (big) begin
      s = 1'b1; pr = e_neg_r ? 32'h80000000 : 32'h7FFFFFFF;
    end else if (e_neg_r) begin
      if (q > 51'h80000000) begin s = 1'b1; pr = 32'h80000000; end
      else pr = 32'd0 - q[31:0];
    end else begin
      if (q > 51'h7FFFFFFF) begin s = 1'b1; pr = 32'h7FFFFFFF; end
      else pr = q[31:0];
    end
    if (adv) begin
      f_res_r.density_out  <= e_c_r.density;
      f_res_r.tracer_out   <= e_c_r.tracer;
      f_res_r.zero_density <= e_c_r.zero;
      f_res_r.velocity_x   <= e_c_r.zero ? 32'd0 : e_vel_r[0];
      f_res_r.velocity_y   <= e_c_r.zero ? 32'd0 : e_vel_r[1];
      f_res_r.velocity_z   <= e_c_r.zero ? 32'd0 : e_vel_r[2];
      f_res_r.pressure     <= e_c_r.zero ? 32'd0 : pr;
      f_res_r.saturated    <= e_c_r.zero ? 1'b0 : (e_sat_r | s);
    end
    if (!rst_n) f_v_r <= 1'b0; else if (adv) f_v_r <= e_v_r;
  end

  // output queue
  c2p_res_t       omem_r [ODepth];
  logic [OAw-1:0] owp_r, orp_r;
  logic           otake, owr;
  assign otake     = res_take && res_valid;
  assign owr       = f_v_r && adv;
  assign res_valid = (ocnt_r != '0);
  assign res       = omem_r[orp_r];

  always_comb begin
    ocnt_nxt = ocnt_r + {{OAw{1'b0}}, owr} - {{OAw{1'b0}}, otake};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r <= '0; orp_r <= '0; ocnt_r <= '0;
    end else begin
      if (owr) owp_r <= owp_r + 1'b1;
      if (otake) orp_r <= orp_r + 1'b1;
      ocnt_r <= ocnt_nxt;
    end
    if (owr) omem_r[owp_r] <= f_res_r;
  end

  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= (OAw+1)'(ODepth)) else $error("output queue overrun");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    f_v_r && f_res_r.zero_density |-> !f_res_r.saturated) else $error("zero flagged saturated");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !res_valid |-> !otake) else $error("pop from empty");
endmodule

/* design/conserved_to_primitive.sv */
// Top level: Euler conserved-to-primitive conversion, Q16.16 fixed point.
//
//  channel  | ports                                   | handshake
//  input    | in_density .. in_tracer_in              | in_push / in_full
//  result   | out_density_out .. out_saturated        | out_pop / out_empty
//  config   | cfg_gamma_minus_one                     | cfg_we, no wait
//
// One cell per cycle sustained while the output queue has room; each beat
// runs through the 48-stage restoring divider, one quotient bit per stage.
// Reset (rst_n low, synchronous) empties both queues and loads gamma 0.4.
// A full output queue with a finished beat waiting freezes the whole back-end
// pipe; the four-entry input queue then fills and raises in_full.
module conserved_to_primitive (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [31:0]                in_density,
  input  logic signed [31:0]         in_momentum_x,
  input  logic signed [31:0]         in_momentum_y,
  input  logic signed [31:0]         in_momentum_z,
  input  logic [31:0]                in_total_energy,
  input  logic [31:0]                in_tracer_in,
  input  logic                       out_pop,
  output logic                       out_empty,
  output logic [31:0]                out_density_out,
  output logic signed [31:0]         out_velocity_x,
  output logic signed [31:0]         out_velocity_y,
  output logic signed [31:0]         out_velocity_z,
  output logic signed [31:0]         out_pressure,
  output logic [31:0]                out_tracer_out,
  output logic                       out_zero_density,
  output logic                       out_saturated,
  input  logic                       cfg_we,
  input  logic [c2p_pkg::GammaW-1:0] cfg_gamma_minus_one
);
  import c2p_pkg::*;

  logic [GammaW-1:0] gamma_r;
  logic              q_valid, q_take, res_valid;
  c2p_cell_t         q_cell;
  c2p_res_t          res;

  // hold gamma; reload the default on reset
  always_ff @(posedge clk) begin
    if (!rst_n) gamma_r <= GammaReset;
    else if (cfg_we) gamma_r <= cfg_gamma_minus_one;
  end

  c2p_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_density, .in_momentum_x,
    .in_momentum_y, .in_momentum_z, .in_total_energy, .in_tracer_in,
    .q_valid, .q_take, .q_cell
  );

  c2p_back u_back (
    .clk, .rst_n, .gamma(gamma_r), .q_valid, .q_take, .q_cell,
    .res_valid, .res_take(out_pop), .res
  );

  assign out_empty        = !res_valid;
  assign out_density_out  = res.density_out;
  assign out_velocity_x   = res.velocity_x;
  assign out_velocity_y   = res.velocity_y;
  assign out_velocity_z   = res.velocity_z;
  assign out_pressure     = res.pressure;
  assign out_tracer_out   = res.tracer_out;
  assign out_zero_density = res.zero_density;
  assign out_saturated    = res.saturated;
endmodule
